// ----- rtl/crc16_frame_deframer_assert.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef CRC16_FRAME_DEFRAMER_ASSERT_SVH
`define CRC16_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define CRC16FD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("crc16fd assertion failed");
// Check a property on every clock edge, reset included.
`define CRC16FD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("crc16fd assertion failed");
`else
`define CRC16FD_ASSERT(lbl, clk, rst_n, prop)
`define CRC16FD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- rtl/crc16fd_pkg.sv -----
// Shared types, constants and the CRC byte step of the frame deframer.
`timescale 1ns / 1ps
`default_nettype none
package crc16fd_pkg;

    localparam int MAX_PAYLOAD = 16;
    localparam int HDR_BYTES   = 4;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int POS_W       = $clog2(MAX_PAYLOAD);
    localparam int HDR_W       = $clog2(HDR_BYTES);

    localparam logic [7:0]  MARKER_RESET = 8'hA5;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY     = 16'h1021;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_HEADER,
        ST_PAYLOAD,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_marker;
        logic load_hdr;
        logic load_pay;
        logic load_crc_lo;
        logic clr_idx;
        logic emit_one;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic marker_hit;
        logic hdr_last;
        logic len_bad;
        logic len_zero;
        logic pay_last;
        logic crc_ok;
        logic emit_last;
        logic out_free;
    } sts_t;

    // CRC-16-CCITT, MSB first, one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/crc16fd_ctrl.sv -----
// Frame controller: hunt, header, payload, CRC and emit sequencing.
`timescale 1ns / 1ps
`default_nettype none
`include "crc16_frame_deframer_assert.svh"
module crc16fd_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire crc16fd_pkg::sts_t sts,
    output crc16fd_pkg::cmd_t      cmd
);

    crc16fd_pkg::state_t state_reg;
    crc16fd_pkg::state_t state_next;
    logic                acc;

    assign s_ready = (state_reg != crc16fd_pkg::ST_EMIT);
    assign acc     = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= crc16fd_pkg::ST_HUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            crc16fd_pkg::ST_HUNT: begin
                if (acc && sts.marker_hit) state_next = crc16fd_pkg::ST_HEADER;
            end
            crc16fd_pkg::ST_HEADER: begin
                if (acc && sts.hdr_last) begin
                    if (sts.len_bad) begin
                        state_next = crc16fd_pkg::ST_HUNT;
                    end else if (sts.len_zero) begin
                        state_next = crc16fd_pkg::ST_CRC_LO;
                    end else begin
                        state_next = crc16fd_pkg::ST_PAYLOAD;
                    end
                end
            end
            crc16fd_pkg::ST_PAYLOAD: begin
                if (acc && sts.pay_last) state_next = crc16fd_pkg::ST_CRC_LO;
            end
            crc16fd_pkg::ST_CRC_LO: begin
                if (acc) state_next = crc16fd_pkg::ST_CRC_HI;
            end
            crc16fd_pkg::ST_CRC_HI: begin
                if (acc) begin
                    state_next = sts.crc_ok ? crc16fd_pkg::ST_EMIT : crc16fd_pkg::ST_HUNT;
                end
            end
            crc16fd_pkg::ST_EMIT: begin
                if (sts.out_free && sts.emit_last) state_next = crc16fd_pkg::ST_HUNT;
            end
            default: begin
                state_next = crc16fd_pkg::ST_HUNT;
            end
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            crc16fd_pkg::ST_HUNT:    cmd.load_marker = acc && sts.marker_hit;
            crc16fd_pkg::ST_HEADER:  cmd.load_hdr    = acc;
            crc16fd_pkg::ST_PAYLOAD: cmd.load_pay    = acc;
            crc16fd_pkg::ST_CRC_LO:  cmd.load_crc_lo = acc;
            crc16fd_pkg::ST_CRC_HI:  cmd.clr_idx     = acc;
            crc16fd_pkg::ST_EMIT:    cmd.emit_one    = sts.out_free;
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Emission is entered only from a good second CRC byte.
    `CRC16FD_ASSERT(a_emit_entry, aclk, aresetn,
        (state_reg == crc16fd_pkg::ST_EMIT && $past(state_reg) != crc16fd_pkg::ST_EMIT)
            |-> $past(state_reg) == crc16fd_pkg::ST_CRC_HI)
    // No request is taken while a frame is being emitted.
    `CRC16FD_ASSERT(a_no_take_in_emit, aclk, aresetn,
        (state_reg == crc16fd_pkg::ST_EMIT)
            |-> !(cmd.load_marker || cmd.load_hdr || cmd.load_pay || cmd.load_crc_lo))

endmodule
`default_nettype wire

// ----- rtl/crc16fd_dp.sv -----
// Deframer datapath: marker, header, payload store, CRC and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "crc16_frame_deframer_assert.svh"
module crc16fd_dp (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    input  wire logic [7:0]                       cfg_start_marker,
    input  wire logic [7:0]                       s_rx_byte,
    input  wire crc16fd_pkg::cmd_t                cmd,
    output crc16fd_pkg::sts_t                     sts,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_service_id,
    output logic [7:0]                            m_command_id,
    output logic [7:0]                            m_sequence_num,
    output logic [crc16fd_pkg::LEN_W-1:0]         m_payload_count,
    output logic                                  m_has_byte,
    output logic [crc16fd_pkg::POS_W-1:0]         m_byte_position,
    output logic [7:0]                            m_payload_value,
    output logic                                  m_end_of_frame
);

    localparam int LW = crc16fd_pkg::LEN_W;
    localparam int PW = crc16fd_pkg::POS_W;

    logic [7:0]    marker_reg;
    logic [15:0]   crc_reg;
    logic [7:0]    crc_lo_reg;
    logic [LW-1:0] idx_reg;
    logic [LW-1:0] len_reg;
    logic [7:0]    hdr_reg [crc16fd_pkg::HDR_BYTES];
    logic [7:0]    store   [crc16fd_pkg::MAX_PAYLOAD];

    logic          m_valid_reg;
    logic [7:0]    m_service_id_reg;
    logic [7:0]    m_command_id_reg;
    logic [7:0]    m_sequence_num_reg;
    logic [LW-1:0] m_payload_count_reg;
    logic          m_has_byte_reg;
    logic [PW-1:0] m_byte_position_reg;
    logic [7:0]    m_payload_value_reg;
    logic          m_end_of_frame_reg;

    logic          len_empty;

    assign len_empty = (len_reg == '0);

    assign sts.marker_hit = (s_rx_byte == marker_reg);
    assign sts.hdr_last   = (idx_reg == LW'(crc16fd_pkg::HDR_BYTES - 1));
    assign sts.len_bad    = (s_rx_byte > 8'(crc16fd_pkg::MAX_PAYLOAD));
    assign sts.len_zero   = (s_rx_byte == 8'h00);
    assign sts.pay_last   = ((idx_reg + LW'(1)) == len_reg);
    assign sts.crc_ok     = ({s_rx_byte, crc_lo_reg} == crc_reg);
    assign sts.emit_last  = len_empty || ((idx_reg + LW'(1)) == len_reg);
    assign sts.out_free   = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg <= crc16fd_pkg::MARKER_RESET;
        end else if (cfg_valid) begin
            marker_reg <= cfg_start_marker;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            crc_reg    <= crc16fd_pkg::CRC_INIT;
            crc_lo_reg <= '0;
        end else begin
            if (cmd.load_marker || cmd.clr_idx) begin
                idx_reg <= '0;
            end else if (cmd.load_hdr) begin
                idx_reg <= sts.hdr_last ? '0 : idx_reg + LW'(1);
            end else if (cmd.load_pay || cmd.emit_one) begin
                idx_reg <= idx_reg + LW'(1);
            end
            if (cmd.load_marker) begin
                crc_reg <= crc16fd_pkg::crc_byte(crc16fd_pkg::CRC_INIT, s_rx_byte);
            end else if (cmd.load_hdr || cmd.load_pay) begin
                crc_reg <= crc16fd_pkg::crc_byte(crc_reg, s_rx_byte);
            end
            if (cmd.load_crc_lo) crc_lo_reg <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_hdr) begin
            hdr_reg[idx_reg[crc16fd_pkg::HDR_W-1:0]] <= s_rx_byte;
            if (sts.hdr_last) len_reg <= s_rx_byte[LW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pay) store[idx_reg[PW-1:0]] <= s_rx_byte;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_one) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_one) begin
            m_service_id_reg    <= hdr_reg[0];
            m_command_id_reg    <= hdr_reg[1];
            m_sequence_num_reg  <= hdr_reg[2];
            m_payload_count_reg <= len_reg;
            m_has_byte_reg      <= !len_empty;
            m_byte_position_reg <= len_empty ? '0 : idx_reg[PW-1:0];
            m_payload_value_reg <= len_empty ? 8'h00 : store[idx_reg[PW-1:0]];
            m_end_of_frame_reg  <= sts.emit_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_service_id    = m_service_id_reg;
    assign m_command_id    = m_command_id_reg;
    assign m_sequence_num  = m_sequence_num_reg;
    assign m_payload_count = m_payload_count_reg;
    assign m_has_byte      = m_has_byte_reg;
    assign m_byte_position = m_byte_position_reg;
    assign m_payload_value = m_payload_value_reg;
    assign m_end_of_frame  = m_end_of_frame_reg;

    // A result never overwrites one that has not been taken.
    `CRC16FD_ASSERT(a_no_overwrite, aclk, aresetn,
        cmd.emit_one |-> (!m_valid_reg || m_ready))
    // Payload writes stay inside the store.
    `CRC16FD_ASSERT(a_store_bound, aclk, aresetn,
        cmd.load_pay |-> (idx_reg < LW'(crc16fd_pkg::MAX_PAYLOAD)))
    // The last byte of a non-empty frame carries the last position.
    `CRC16FD_ASSERT(a_eof_position, aclk, aresetn,
        (m_valid_reg && m_end_of_frame_reg && m_has_byte_reg)
            |-> (({1'b0, m_byte_position_reg} + LW'(1)) == m_payload_count_reg))

endmodule
`default_nettype wire

// ----- rtl/crc16_frame_deframer.sv -----
// Top level of the magic/length/CRC-16-CCITT frame deframer.
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one received byte per cycle while a frame is collected or hunted.
// After the second CRC byte, the result register loads once the output is free.
// A good frame then emits max(length,1) results, one per cycle at full m_ready,
// and no byte is taken during that burst (the frame store is being read out).
// Reset: synchronous on aresetn low; hunt state, CRC 0xFFFF, marker 0xA5.
module crc16_frame_deframer (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Configuration: start marker byte, taken whenever valid.
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [7:0]                       cfg_start_marker,
    // Received byte stream.
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_rx_byte,
    // Validated frame results, one per payload byte (one for an empty payload).
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_service_id,
    output logic [7:0]                            m_command_id,
    output logic [7:0]                            m_sequence_num,
    output logic [crc16fd_pkg::LEN_W-1:0]         m_payload_count,
    output logic                                  m_has_byte,
    output logic [crc16fd_pkg::POS_W-1:0]         m_byte_position,
    output logic [7:0]                            m_payload_value,
    output logic                                  m_end_of_frame
);

    crc16fd_pkg::cmd_t cmd;
    crc16fd_pkg::sts_t sts;

    // The marker register accepts a request on every cycle.
    assign cfg_ready = 1'b1;

    // Sequence the frame: hunt, header, payload, CRC bytes, then emit.
    crc16fd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Hold the marker, header and payload; advance the CRC; drive results.
    crc16fd_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_start_marker (cfg_start_marker),
        .s_rx_byte        (s_rx_byte),
        .cmd              (cmd),
        .sts              (sts),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_service_id     (m_service_id),
        .m_command_id     (m_command_id),
        .m_sequence_num   (m_sequence_num),
        .m_payload_count  (m_payload_count),
        .m_has_byte       (m_has_byte),
        .m_byte_position  (m_byte_position),
        .m_payload_value  (m_payload_value),
        .m_end_of_frame   (m_end_of_frame)
    );

endmodule
`default_nettype wire

// ----- tb/crc16_frame_deframer_test.sv -----
// Self-checking testbench of the CRC-16 frame deframer: table-driven frames, then random traffic.
`timescale 1ns / 1ps
module crc16_frame_deframer_test;

    // Marker plus service, command, sequence and length.
    localparam int HEAD_LEN        = 5;
    localparam int STORE_LEN       = HEAD_LEN + crc16fd_pkg::MAX_PAYLOAD;
    localparam int COUNT_W         = crc16fd_pkg::LEN_W;
    localparam int INDEX_W         = crc16fd_pkg::POS_W;
    // Long receiver hold-off, long enough to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 300;
    // Quiet time after the last result, with margin for the block to settle.
    localparam int SETTLE_CYCLES   = 12;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int REPORT_LIMIT    = 10;
    // Each random marker phase runs until it has sent this many bytes and results.
    localparam int PHASE_BYTES     = 6;
    localparam int PHASE_RESULTS   = 1;
    localparam int PHASE_COUNT     = 3;

    typedef struct packed {
        logic [7:0]         service_id;
        logic [7:0]         command_id;
        logic [7:0]         sequence_num;
        logic [COUNT_W-1:0] payload_count;
        logic               has_byte;
        logic [INDEX_W-1:0] byte_position;
        logic [7:0]         payload_value;
        logic               end_of_frame;
    } frame_result_t;

    typedef enum logic [2:0] {
        FR_NOISE,       // one stray byte
        FR_GOOD,        // complete frame with a matching CRC
        FR_BAD_CRC,     // complete frame with a corrupted CRC
        FR_OVERSIZE,    // header whose length exceeds the payload limit
        FR_TRUNC        // good frame cut short
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [7:0]    service;
        logic [7:0]    command;
        logic [7:0]    seq_num;
        logic [7:0]    len_byte;
        logic [7:0]    fill;      // payload byte 0, or the stray byte itself
        logic [7:0]    step;      // payload byte i is fill + i * step
        logic          scramble;  // random payload bytes instead of fill/step
        logic          typed;     // expectation written out in the row
        logic          emits;     // typed row produces the result in want
        frame_result_t want;
    } frame_row_t;

    // Directed frames, sent with the reset marker 0xA5.
    localparam frame_row_t DIRECTED_ROWS [10] = '{
        // stray bytes during the hunt: drop them
        '{FR_NOISE,    8'h00, 8'h00, 8'h00, 8'd0,   8'h00, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{FR_NOISE,    8'h00, 8'h00, 8'h00, 8'd0,   8'hFF, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        // empty payload: one result without a byte, header at both extremes
        '{FR_GOOD,     8'h00, 8'h00, 8'h00, 8'd0,   8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
          '{8'h00, 8'h00, 8'h00, 5'd0, 1'b0, 4'd0, 8'h00, 1'b1}},
        '{FR_GOOD,     8'hFF, 8'hFF, 8'hFF, 8'd0,   8'h00, 8'h00, 1'b0, 1'b1, 1'b1,
          '{8'hFF, 8'hFF, 8'hFF, 5'd0, 1'b0, 4'd0, 8'h00, 1'b1}},
        // length just above the limit and at the top of the byte: back to the hunt
        '{FR_OVERSIZE, 8'h21, 8'h42, 8'h63, 8'd17,  8'h00, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        '{FR_OVERSIZE, 8'h84, 8'h21, 8'h00, 8'd255, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        // bad CRC on an empty frame: no result
        '{FR_BAD_CRC,  8'h12, 8'h34, 8'h56, 8'd0,   8'h00, 8'h00, 1'b0, 1'b1, 1'b0, '0},
        // marker value inside the header and the payload is plain data
        '{FR_GOOD,     8'hA5, 8'h5A, 8'h01, 8'd1,   8'hA5, 8'h00, 1'b0, 1'b0, 1'b0, '0},
        // full payload, bytes 00, 11, ... FF; then a bad CRC on a two-byte frame
        '{FR_GOOD,     8'h3C, 8'hC3, 8'h80, 8'd16,  8'h00, 8'h11, 1'b0, 1'b0, 1'b0, '0},
        '{FR_BAD_CRC,  8'h77, 8'h88, 8'h99, 8'd2,   8'hFF, 8'h00, 1'b0, 1'b1, 1'b0, '0}
    };

    logic                aclk             = 1'b0;
    logic                aresetn          = 1'b0;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_start_marker = crc16fd_pkg::MARKER_RESET;
    logic                s_valid          = 1'b0;
    logic                s_ready;
    logic [7:0]          s_rx_byte        = 8'h00;
    logic                m_valid;
    logic                m_ready          = 1'b0;
    logic [7:0]          m_service_id;
    logic [7:0]          m_command_id;
    logic [7:0]          m_sequence_num;
    logic [COUNT_W-1:0]  m_payload_count;
    logic                m_has_byte;
    logic [INDEX_W-1:0]  m_byte_position;
    logic [7:0]          m_payload_value;
    logic                m_end_of_frame;

    // Deframer shadow state.
    logic [7:0]          marker_reg;
    logic [7:0]          frame_bytes [STORE_LEN];
    int                  held;
    logic [15:0]         crc_run;
    logic [7:0]          crc_first;
    frame_result_t       expected_results [$];

    int                  bytes_sent        = 0;
    int                  results_predicted = 0;
    int                  results_seen      = 0;
    int                  mismatches        = 0;
    int                  markers_written   = 0;
    int                  cycle_count       = 0;
    logic                gaps_on           = 1'b1;
    logic                pressure_armed    = 1'b0;
    logic                pressure_done     = 1'b0;

    crc16_frame_deframer dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_start_marker (cfg_start_marker),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_service_id     (m_service_id),
        .m_command_id     (m_command_id),
        .m_sequence_num   (m_sequence_num),
        .m_payload_count  (m_payload_count),
        .m_has_byte       (m_has_byte),
        .m_byte_position  (m_byte_position),
        .m_payload_value  (m_payload_value),
        .m_end_of_frame   (m_end_of_frame)
    );

    initial begin : clock_gen
        forever #5 aclk = ~aclk;
    end

    // CRC-16-CCITT, one data bit at a time, MSB first.
    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--) begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ crc16fd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void hunt_restart();
        held      = 0;
        crc_run   = crc16fd_pkg::CRC_INIT;
        crc_first = 8'h00;
    endfunction

    // Advance the shadow deframer by one accepted byte; queue the results of a good frame.
    function automatic void deframe_step(input logic [7:0] b, input logic record);
        int            len;
        int            count;
        frame_result_t res;
        if (held == 0) begin
            // Hunt: anything but the marker is dropped.
            if (b == marker_reg) begin
                frame_bytes[0] = b;
                crc_run        = crc_next(crc16fd_pkg::CRC_INIT, b);
                held           = 1;
            end
            return;
        end
        if (held < HEAD_LEN) begin
            frame_bytes[held] = b;
            crc_run           = crc_next(crc_run, b);
            held++;
            // Oversized length: drop the frame once the length byte is in.
            if (held == HEAD_LEN && int'(b) > crc16fd_pkg::MAX_PAYLOAD) begin
                hunt_restart();
            end
            return;
        end
        len = int'(frame_bytes[HEAD_LEN-1]);
        if (held < HEAD_LEN + len) begin
            frame_bytes[held] = b;
            crc_run           = crc_next(crc_run, b);
            held++;
            return;
        end
        if (held == HEAD_LEN + len) begin
            crc_first = b;
            held++;
            return;
        end
        // Second CRC byte, little-endian on the link.
        if ({b, crc_first} == crc_run) begin
            count = (len == 0) ? 1 : len;
            for (int i = 0; i < count; i++) begin
                res.service_id    = frame_bytes[1];
                res.command_id    = frame_bytes[2];
                res.sequence_num  = frame_bytes[3];
                res.payload_count = COUNT_W'(len);
                res.has_byte      = (len != 0);
                res.byte_position = (len == 0) ? '0 : INDEX_W'(i);
                res.payload_value = (len == 0) ? 8'h00 : frame_bytes[HEAD_LEN + i];
                res.end_of_frame  = (i == count - 1);
                if (record) begin
                    expected_results.push_back(res);
                end
            end
            if (record) begin
                results_predicted += count;
            end
        end
        hunt_restart();
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic frame_row_t random_row();
        frame_row_t r;
        int         pick;
        r    = '0;
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
            r.kind = FR_GOOD;
        end else if (pick < 78) begin
            r.kind = FR_BAD_CRC;
        end else if (pick < 85) begin
            r.kind = FR_OVERSIZE;
        end else if (pick < 93) begin
            r.kind = FR_TRUNC;
        end else begin
            r.kind = FR_NOISE;
        end
        r.service  = 8'($urandom);
        r.command  = 8'($urandom);
        r.seq_num  = 8'($urandom);
        r.fill     = 8'($urandom);
        r.scramble = 1'b1;
        // Keep most payloads short, with a few long and full ones.
        pick = $urandom_range(0, 19);
        if (r.kind == FR_OVERSIZE) begin
            r.len_byte = 8'($urandom_range(crc16fd_pkg::MAX_PAYLOAD + 1, 255));
        end else if (pick == 0) begin
            r.len_byte = 8'(crc16fd_pkg::MAX_PAYLOAD);
        end else if (pick < 4) begin
            r.len_byte = 8'($urandom_range(7, crc16fd_pkg::MAX_PAYLOAD - 1));
        end else begin
            r.len_byte = 8'($urandom_range(0, 6));
        end
        return r;
    endfunction

    function automatic string describe(input frame_result_t r);
        return $sformatf("svc %02h cmd %02h seq %02h count %0d has %0b pos %0d value %02h eof %0b",
                         r.service_id, r.command_id, r.sequence_num, r.payload_count,
                         r.has_byte, r.byte_position, r.payload_value, r.end_of_frame);
    endfunction

    // Offer one byte at a falling edge, hold it until the request is taken.
    task automatic feed_byte(input logic [7:0] b, input logic record);
        int gap;
        gap = gaps_on ? idle_len() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        deframe_step(b, record);
        bytes_sent++;
    endtask

    // Build the byte stream of one row under the current marker and send it.
    task automatic send_frame(input frame_row_t r, input logic record);
        logic [7:0]  bytes_q [$];
        logic [15:0] crc;
        int          keep;
        if (r.kind == FR_NOISE) begin
            bytes_q.push_back(r.fill);
        end else begin
            bytes_q.push_back(marker_reg);
            bytes_q.push_back(r.service);
            bytes_q.push_back(r.command);
            bytes_q.push_back(r.seq_num);
            bytes_q.push_back(r.len_byte);
            if (r.kind != FR_OVERSIZE) begin
                for (int i = 0; i < int'(r.len_byte); i++) begin
                    bytes_q.push_back(r.scramble ? 8'($urandom) : 8'(r.fill + i * r.step));
                end
                crc = crc16fd_pkg::CRC_INIT;
                foreach (bytes_q[k]) begin
                    crc = crc_next(crc, bytes_q[k]);
                end
                if (r.kind == FR_BAD_CRC) begin
                    crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
                end
                bytes_q.push_back(crc[7:0]);
                bytes_q.push_back(crc[15:8]);
            end
        end
        if (r.kind == FR_TRUNC) begin
            keep = $urandom_range(1, bytes_q.size() - 1);
            while (bytes_q.size() > keep) void'(bytes_q.pop_back());
        end
        foreach (bytes_q[k]) begin
            feed_byte(bytes_q[k], record);
        end
    endtask

    // Write the start marker once the block has drained and gone quiet.
    task automatic write_marker(input logic [7:0] value);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid        <= 1'b1;
        cfg_start_marker <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        marker_reg = value;
        markers_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        frame_row_t row;
        logic [7:0] next_marker;
        int         phase_bytes_start;
        int         phase_results_start;
        marker_reg = crc16fd_pkg::MARKER_RESET;
        hunt_restart();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        // Hold the receiver off while the directed frames keep coming.
        pressure_armed = 1'b1;

        // Directed table: typed rows supply their own expectation.
        foreach (DIRECTED_ROWS[i]) begin
            row = DIRECTED_ROWS[i];
            if (row.typed && row.emits) begin
                expected_results.push_back(row.want);
            end
            send_frame(row, !row.typed);
        end

        // Random traffic under marker 00, FF and a random value.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase == 0) begin
                next_marker = 8'h00;
            end else if (phase == 1) begin
                next_marker = 8'hFF;
            end else begin
                next_marker = 8'($urandom);
            end
            write_marker(next_marker);
            phase_bytes_start   = bytes_sent;
            phase_results_start = results_predicted;
            while (bytes_sent - phase_bytes_start < PHASE_BYTES ||
                   results_predicted - phase_results_start < PHASE_RESULTS) begin
                // Some frames go out back to back.
                gaps_on = ($urandom_range(0, 3) != 0);
                send_frame(random_row(), 1'b1);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        $display("Sent %0d link bytes under %0d marker writes; checked %0d frame results.",
                 bytes_sent, markers_written, results_seen);
        $display("Empty, full, oversize, bad-CRC, cut-short frames, stray bytes; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("[crc16_frame_deframer] OK");
        end else begin
            $display("[crc16_frame_deframer] ERROR");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off while the sender keeps going.
    initial begin : result_sink
        int run;
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (pressure_armed && !pressure_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                pressure_done = 1'b1;
            end
            m_ready <= 1'b1;
            run = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
            repeat (run) @(negedge aclk);
            gap = idle_len();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge aclk) begin : result_check
        frame_result_t got;
        frame_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got.service_id    = m_service_id;
            got.command_id    = m_command_id;
            got.sequence_num  = m_sequence_num;
            got.payload_count = m_payload_count;
            got.has_byte      = m_has_byte;
            got.byte_position = m_byte_position;
            got.payload_value = m_payload_value;
            got.end_of_frame  = m_end_of_frame;
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result %0d not expected: %s", results_seen, describe(got));
                end
            end else begin
                want = expected_results.pop_front();
                if (got.service_id    !== want.service_id    ||
                    got.command_id    !== want.command_id    ||
                    got.sequence_num  !== want.sequence_num  ||
                    got.payload_count !== want.payload_count ||
                    got.has_byte      !== want.has_byte      ||
                    got.byte_position !== want.byte_position ||
                    got.payload_value !== want.payload_value ||
                    got.end_of_frame  !== want.end_of_frame) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("result %0d mismatch", results_seen);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                end
            end
        end
    end

    // Stop a hung run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("[crc16_frame_deframer] ERROR");
        $finish;
    end

endmodule
